/* rtl/core/jts_pkg.sv */
// Shared types, token codes and literal tables for the JSON token scanner.
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_RESULTS     = 3;

    localparam logic [3:0] TOK_EOF    = 4'd0;
    localparam logic [3:0] TOK_LBRACE = 4'd1;
    localparam logic [3:0] TOK_RBRACE = 4'd2;
    localparam logic [3:0] TOK_LBRACK = 4'd3;
    localparam logic [3:0] TOK_RBRACK = 4'd4;
    localparam logic [3:0] TOK_COLON  = 4'd5;
    localparam logic [3:0] TOK_COMMA  = 4'd6;
    localparam logic [3:0] TOK_STRING = 4'd7;
    localparam logic [3:0] TOK_NUMBER = 4'd8;
    localparam logic [3:0] TOK_TRUE   = 4'd9;
    localparam logic [3:0] TOK_ERROR  = 4'd12;
    localparam logic [3:0] TOK_BYTE   = 4'd13;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_code;
        logic [7:0]  decoded_byte;
        logic [15:0] string_length;
        logic        run_end;
    } t_out_item;

    // All results caused by one input byte, in order.
    typedef struct packed {
        t_out_item [MAX_RESULTS-1:0] res;
        logic [1:0]                  cnt;
    } t_entry;

    typedef enum logic [5:0] {
        MODE_GROUND  = 6'b000001,
        MODE_NUMBER  = 6'b000010,
        MODE_STRING  = 6'b000100,
        MODE_ESCAPE  = 6'b001000,
        MODE_HEX     = 6'b010000,
        MODE_LITERAL = 6'b100000
    } t_scan_mode;

    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        unique case (sel)
            LIT_TRUE:  lit_len = 3'd4;
            LIT_FALSE: lit_len = 3'd5;
            LIT_NULL:  lit_len = 3'd4;
            default:   lit_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case ({sel, pos})
            {LIT_TRUE, 3'd0}:  ch = "t";
            {LIT_TRUE, 3'd1}:  ch = "r";
            {LIT_TRUE, 3'd2}:  ch = "u";
            {LIT_TRUE, 3'd3}:  ch = "e";
            {LIT_FALSE, 3'd0}: ch = "f";
            {LIT_FALSE, 3'd1}: ch = "a";
            {LIT_FALSE, 3'd2}: ch = "l";
            {LIT_FALSE, 3'd3}: ch = "s";
            {LIT_FALSE, 3'd4}: ch = "e";
            {LIT_NULL, 3'd0}:  ch = "n";
            {LIT_NULL, 3'd1}:  ch = "u";
            {LIT_NULL, 3'd2}:  ch = "l";
            {LIT_NULL, 3'd3}:  ch = "l";
            default:           ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/jts_front.sv */
// Front end: scan state, byte classification and the result list of each byte.
`timescale 1ns / 1ps
`default_nettype none

module jts_front import jts_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_entry        o_entry
);

    t_scan_mode             r_mode, n_mode;
    logic [11:0]            r_hex, n_hex;
    logic [1:0]             r_digits, n_digits;
    logic [1:0]             r_sel, n_sel;
    logic [2:0]             r_pos, n_pos;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_err, n_err;

    logic [7:0]  c;
    logic        fin;
    logic        in_str;
    logic        do_ground;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp;
    logic [2:0]  pos_next;
    logic        lit_bad;
    t_entry      v_e;

    function automatic t_entry f_put(input t_entry e, input logic [3:0] code,
                                     input logic [7:0] b, input logic [15:0] l);
        t_entry r;
        r = e;
        if (r.cnt != 2'd3) begin
            r.res[r.cnt] = '{token_code: code, decoded_byte: b, string_length: l,
                             run_end: 1'b0};
            r.cnt = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] f_sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // The count is shown clipped to sixteen bits.
    function automatic logic [15:0] f_clip(input logic [LENGTH_BITS-1:0] v);
        logic [LENGTH_BITS+15:0] ext;
        ext = {16'b0, v};
        return (|ext[LENGTH_BITS+15:16]) ? 16'hFFFF : ext[15:0];
    endfunction

    assign c      = i_item.text_byte;
    assign fin    = i_item.final_byte;
    assign in_str = (r_mode == MODE_STRING) || (r_mode == MODE_ESCAPE) || (r_mode == MODE_HEX);

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= "0" && c <= "9") begin
            hex_val = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            hex_val = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            hex_val = 4'(c - "A" + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp       = {r_hex, hex_val};
    assign pos_next = r_pos + 3'd1;
    assign lit_bad  = (r_sel == 2'd3) || (r_pos >= lit_len(r_sel)) ||
                      (lit_char(r_sel, r_pos) != c);

    always_comb begin
        n_mode    = r_mode;
        n_hex     = r_hex;
        n_digits  = r_digits;
        n_sel     = r_sel;
        n_pos     = r_pos;
        n_len     = r_len;
        n_err     = r_err;
        v_e       = '0;
        do_ground = 1'b0;

        // A final byte inside a string is dropped unless it closes the string.
        if (!r_err && !(in_str && fin && !(r_mode == MODE_STRING && c == "\""))) begin
            unique case (r_mode)
                MODE_NUMBER: begin
                    if (!((c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
                          c == "+" || c == "-")) begin
                        v_e       = f_put(v_e, TOK_NUMBER, 8'h00, 16'h0000);
                        n_mode    = MODE_GROUND;
                        do_ground = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == "\"") begin
                        v_e    = f_put(v_e, TOK_STRING, 8'h00, f_clip(r_len));
                        n_len  = '0;
                        n_mode = MODE_GROUND;
                    end else if (c == "\\") begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        v_e   = f_put(v_e, TOK_BYTE, c, 16'h0000);
                        n_len = f_sat_inc(r_len);
                    end
                end
                MODE_ESCAPE: begin
                    n_mode = MODE_STRING;
                    unique case (c)
                        "\"", "\\", "/": begin
                            v_e   = f_put(v_e, TOK_BYTE, c, 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end
                        "b": begin
                            v_e   = f_put(v_e, TOK_BYTE, 8'h08, 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end
                        "f": begin
                            v_e   = f_put(v_e, TOK_BYTE, 8'h0C, 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end
                        "n": begin
                            v_e   = f_put(v_e, TOK_BYTE, 8'h0A, 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end
                        "r": begin
                            v_e   = f_put(v_e, TOK_BYTE, 8'h0D, 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end
                        "t": begin
                            v_e   = f_put(v_e, TOK_BYTE, 8'h09, 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end
                        "u": begin
                            n_hex    = '0;
                            n_digits = '0;
                            n_mode   = MODE_HEX;
                        end
                        default: begin
                            v_e    = f_put(v_e, TOK_ERROR, 8'h00, 16'h0000);
                            n_err  = 1'b1;
                            n_mode = MODE_GROUND;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (!hex_ok) begin
                        v_e    = f_put(v_e, TOK_ERROR, 8'h00, 16'h0000);
                        n_err  = 1'b1;
                        n_mode = MODE_GROUND;
                    end else if (r_digits != 2'd3) begin
                        n_hex    = cp[11:0];
                        n_digits = r_digits + 2'd1;
                    end else begin
                        n_hex    = '0;
                        n_digits = '0;
                        n_mode   = MODE_STRING;
                        // The code point goes out as UTF-8 without pairing surrogates.
                        if (cp < 16'h0080) begin
                            v_e   = f_put(v_e, TOK_BYTE, cp[7:0], 16'h0000);
                            n_len = f_sat_inc(r_len);
                        end else if (cp < 16'h0800) begin
                            v_e   = f_put(v_e, TOK_BYTE, {3'b110, cp[10:6]}, 16'h0000);
                            v_e   = f_put(v_e, TOK_BYTE, {2'b10, cp[5:0]}, 16'h0000);
                            n_len = f_sat_inc(f_sat_inc(r_len));
                        end else begin
                            v_e   = f_put(v_e, TOK_BYTE, {4'b1110, cp[15:12]}, 16'h0000);
                            v_e   = f_put(v_e, TOK_BYTE, {2'b10, cp[11:6]}, 16'h0000);
                            v_e   = f_put(v_e, TOK_BYTE, {2'b10, cp[5:0]}, 16'h0000);
                            n_len = f_sat_inc(f_sat_inc(f_sat_inc(r_len)));
                        end
                    end
                end
                MODE_LITERAL: begin
                    if (lit_bad) begin
                        v_e    = f_put(v_e, TOK_ERROR, 8'h00, 16'h0000);
                        n_err  = 1'b1;
                        n_mode = MODE_GROUND;
                    end else if (pos_next >= lit_len(r_sel)) begin
                        v_e    = f_put(v_e, TOK_TRUE + {2'b00, r_sel}, 8'h00, 16'h0000);
                        n_mode = MODE_GROUND;
                        n_pos  = '0;
                    end else begin
                        n_pos = pos_next;
                    end
                end
                default: begin
                    n_mode    = MODE_GROUND;
                    do_ground = 1'b1;
                end
            endcase

            if (do_ground) begin
                unique case (c)
                    " ", "\t", "\n", 8'h0D: begin
                    end
                    "{": v_e = f_put(v_e, TOK_LBRACE, 8'h00, 16'h0000);
                    "}": v_e = f_put(v_e, TOK_RBRACE, 8'h00, 16'h0000);
                    "[": v_e = f_put(v_e, TOK_LBRACK, 8'h00, 16'h0000);
                    "]": v_e = f_put(v_e, TOK_RBRACK, 8'h00, 16'h0000);
                    ":": v_e = f_put(v_e, TOK_COLON, 8'h00, 16'h0000);
                    ",": v_e = f_put(v_e, TOK_COMMA, 8'h00, 16'h0000);
                    "\"": begin
                        n_mode = MODE_STRING;
                        n_len  = '0;
                    end
                    "t": begin
                        n_sel  = LIT_TRUE;
                        n_pos  = 3'd1;
                        n_mode = MODE_LITERAL;
                    end
                    "f": begin
                        n_sel  = LIT_FALSE;
                        n_pos  = 3'd1;
                        n_mode = MODE_LITERAL;
                    end
                    "n": begin
                        n_sel  = LIT_NULL;
                        n_pos  = 3'd1;
                        n_mode = MODE_LITERAL;
                    end
                    default: begin
                        if (c == "-" || (c >= "0" && c <= "9")) begin
                            n_mode = MODE_NUMBER;
                        end else begin
                            v_e    = f_put(v_e, TOK_ERROR, 8'h00, 16'h0000);
                            n_err  = 1'b1;
                            n_mode = MODE_GROUND;
                        end
                    end
                endcase
            end
        end

        if (fin) begin
            if (!n_err) begin
                if (n_mode == MODE_NUMBER) begin
                    v_e = f_put(v_e, TOK_NUMBER, 8'h00, 16'h0000);
                end else if (n_mode != MODE_GROUND) begin
                    v_e = f_put(v_e, TOK_ERROR, 8'h00, 16'h0000);
                end
            end
            v_e      = f_put(v_e, TOK_EOF, 8'h00, 16'h0000);
            n_mode   = MODE_GROUND;
            n_hex    = '0;
            n_digits = '0;
            n_sel    = '0;
            n_pos    = '0;
            n_len    = '0;
            n_err    = 1'b0;
        end

        if (v_e.cnt != 2'd0) begin
            v_e.res[v_e.cnt - 2'd1].run_end = 1'b1;
        end
        o_entry = v_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GROUND;
            r_hex    <= '0;
            r_digits <= '0;
            r_sel    <= '0;
            r_pos    <= '0;
            r_len    <= '0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_hex    <= n_hex;
            r_digits <= n_digits;
            r_sel    <= n_sel;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/jts_queue.sv */
// Short queue of per-byte result lists between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module jts_queue import jts_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_empty,
    output logic        o_full
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_BITS:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_BITS + 1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/jts_back.sv */
// Back end: feeds the head result list to the output register, one a cycle when free.
`timescale 1ns / 1ps
`default_nettype none

module jts_back import jts_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    input  wire logic   i_out_stall,
    output logic        o_pop,
    output logic        o_valid,
    output t_out_item   o_item
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_item;
    logic       load;
    logic       last;

    // The output register can take a new result when empty or being drained.
    assign load  = !r_valid || !i_out_stall;
    assign last  = (r_idx == i_head.cnt - 2'd1);
    assign o_pop = load && !i_empty && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_item <= i_head.res[r_idx];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/core/json_token_scanner.sv */
// Top level of the JSON token scanner: front end, result queue and back end.
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) takes one byte of JSON text per
//   transaction; final_byte marks the last byte of a buffer.
//   Output channel (o_out_valid, i_out_stall, o_out_item) gives one token or decoded
//   string byte per transaction; run_end marks the last result caused by an input byte.
//   A byte causes zero to three results, which pass through the queue and the output
//   register. One byte is taken per cycle while o_in_stall is low; the output side
//   delivers one result per cycle unless the receiver stalls, so a byte with two or three
//   results (a number ended by punctuation, a \u escape, the final byte) goes out in turn.
//   A four-entry queue of per-byte result lists sits between the scanner and the
//   output register; o_in_stall rises only when it is full.
//   When the receiver stalls, the output transaction holds and the queue fills.
//   Reset returns the scanner to ground state, clears any latched error and empties
//   the queue and output register.
//   After a final byte the scanner is back in its reset state for the next buffer.
`timescale 1ns / 1ps
`default_nettype none

module json_token_scanner import jts_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic   in_accept;
    logic   q_push;
    logic   q_pop;
    logic   q_empty;
    logic   q_full;
    t_entry f_entry;
    t_entry q_head;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;
    // Bytes that cause no result take no queue slot.
    assign q_push     = in_accept && (f_entry.cnt != 2'd0);

    jts_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_item  (i_in_item),
        .o_entry (f_entry)
    );

    jts_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_entry(f_entry),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    jts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_empty    (q_empty),
        .i_out_stall(i_out_stall),
        .o_pop      (q_pop),
        .o_valid    (o_out_valid),
        .o_item     (o_out_item)
    );

`ifndef ASSERT_OFF
    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.token_code == TOK_EOF) |-> o_out_item.run_end)
        else $error("EOF token without run_end");

    a_byte_only_with_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.token_code != TOK_BYTE) |->
        (o_out_item.decoded_byte == 8'h00))
        else $error("decoded byte set on a non-byte result");

    a_length_only_with_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.token_code != TOK_STRING) |->
        (o_out_item.string_length == 16'h0000))
        else $error("string length set on a non-string result");

    a_pop_only_when_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out_valid)
        else $error("queue popped without presenting a result");
`endif

endmodule

`default_nettype wire
